[hw/rtl/spq_pkg.sv]
// spq_pkg: shared types, codes and sizes for the sorted priority queue
// no dependencies; imported by the cells and the top level
package spq_pkg;

    localparam int DefCapacity = 32;

    localparam int KeyW  = 10;
    localparam int TagW  = 16;
    localparam int CmdW  = 2;
    localparam int StatW = 2;

    localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
    localparam logic [CmdW-1:0] CMD_POP    = 2'd1;
    localparam logic [CmdW-1:0] CMD_LIST   = 2'd2;

    localparam logic [StatW-1:0] ST_OK    = 2'd0;
    localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
    localparam logic [StatW-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [TagW-1:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     occ;
        logic     is_tail;
    } cell_ctl_t;

endpackage

[hw/rtl/spq_in_if.sv]
// spq_in_if: command channel of the sorted priority queue
// depends on spq_pkg for field widths
interface spq_in_if;
    import spq_pkg::*;

    logic            valid;
    logic            ready;
    logic [CmdW-1:0] cmd;
    logic [1:0]      course;
    logic [6:0]      year;
    logic [6:0]      roll;
    logic [KeyW-1:0] score;

    modport source (output valid, cmd, course, year, roll, score, input ready);
    modport sink   (input valid, cmd, course, year, roll, score, output ready);
endinterface

[hw/rtl/spq_out_if.sv]
// spq_out_if: result channel of the sorted priority queue
// depends on spq_pkg for field widths
interface spq_out_if;
    import spq_pkg::*;

    logic             valid;
    logic             ready;
    logic [StatW-1:0] status;
    logic [1:0]       out_course;
    logic [6:0]       out_year;
    logic [6:0]       out_roll;
    logic [KeyW-1:0]  out_score;
    logic             last;

    modport source (output valid, status, out_course, out_year, out_roll, out_score, last,
                    input ready);
    modport sink   (input valid, status, out_course, out_year, out_roll, out_score, last,
                    output ready);
endinterface

[hw/rtl/sorted_priority_queue_top.sv]
// sorted_priority_queue_top: bounded queue kept sorted by descending score
// depends on spq_pkg, spq_in_if, spq_out_if and spq_cell
//
//  channel | dir | payload                                        | last
//  req     | in  | cmd, course, year, roll, score                 | -
//  rsp     | out | status, out_course, out_year, out_roll,        | on final
//          |     | out_score, last                                | result
//
// insert and pop: one transaction per cycle while rsp is taken and no list runs
// list emits every stored entry in turn, rotating the chain through the head cell
// reset clears fill, list and handshake state only; cell contents need none
// a stalled rsp holds its register and blocks req until it is taken
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int CAPACITY = DefCapacity
)
(
    input  logic clk,
    input  logic rst_n,
    spq_in_if.sink    req,
    spq_out_if.source rsp
);

    localparam int CntW = $clog2(CAPACITY + 1);

    logic [CntW-1:0] fill_reg, fill_next;
    logic [CntW-1:0] list_cnt_reg, list_cnt_next;
    logic            busy_reg, busy_next;
    logic            out_valid_reg, out_valid_next;
    logic [StatW-1:0] out_status_reg, out_status_next;
    entry_t          out_entry_reg, out_entry_next;
    logic            out_last_reg, out_last_next;

    logic     out_free;
    logic     accept;
    logic     full;
    logic     empty;
    cell_op_t op;
    entry_t   new_entry;
    entry_t   cell_q [CAPACITY];
    logic     goes   [CAPACITY];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = !busy_reg && out_free;
    assign accept    = req.valid && req.ready;
    assign full      = (fill_reg == CntW'(CAPACITY));
    assign empty     = (fill_reg == '0);
    assign new_entry = '{key: req.score, tag: {req.course, req.year, req.roll}};

    always_comb
    begin
        op = OP_HOLD;
        if (accept && (req.cmd == CMD_INSERT) && !full)
        begin
            op = OP_INSERT;
        end
        else if (accept && (req.cmd == CMD_POP) && !empty)
        begin
            op = OP_SHIFT;
        end
        else if (busy_reg && out_free)
        begin
            op = OP_SHIFT;
        end
    end

    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_ctl_t ctl;
            entry_t    prev_e;
            entry_t    next_e;
            logic      prev_g;

            assign ctl = '{op:      op,
                           occ:     (CntW'(i) < fill_reg),
                           is_tail: (CntW'(i) == fill_reg - CntW'(1))};

            if (i == 0)
            begin : g_head
                assign prev_e = cell_q[0];
                assign prev_g = 1'b0;
            end
            else
            begin : g_body
                assign prev_e = cell_q[i-1];
                assign prev_g = goes[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_end
                assign next_e = cell_q[i];
            end
            else
            begin : g_mid
                assign next_e = cell_q[i+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_goes  (prev_g),
                .next_entry (next_e),
                .head_entry (cell_q[0]),
                .entry      (cell_q[i]),
                .goes       (goes[i])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next       = fill_reg;
        list_cnt_next   = list_cnt_reg;
        busy_next       = busy_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;

        if (busy_reg && out_free)
        begin
            // list step: emit head, chain rotates
            out_valid_next  = 1'b1;
            out_status_next = ST_OK;
            out_entry_next  = cell_q[0];
            out_last_next   = (list_cnt_reg == CntW'(1));
            list_cnt_next   = list_cnt_reg - CntW'(1);
            busy_next       = (list_cnt_reg != CntW'(1));
        end
        else if (accept)
        begin
            out_entry_next = '0;
            out_last_next  = 1'b1;
            case (req.cmd)
                CMD_INSERT:
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = full ? ST_FULL : ST_OK;
                    if (!full)
                    begin
                        fill_next = fill_reg + CntW'(1);
                    end
                end
                CMD_POP:
                begin
                    out_valid_next = 1'b1;
                    if (empty)
                    begin
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        out_status_next = ST_OK;
                        out_entry_next  = cell_q[0];
                        fill_next       = fill_reg - CntW'(1);
                    end
                end
                CMD_LIST:
                begin
                    if (empty)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        busy_next     = 1'b1;
                        list_cnt_next = fill_reg;
                    end
                end
                default:
                begin
                    out_entry_next = out_entry_reg;
                    out_last_next  = out_last_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            list_cnt_reg  <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            list_cnt_reg  <= list_cnt_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_entry_reg  <= out_entry_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.out_course = out_entry_reg.tag[15:14];
    assign rsp.out_year   = out_entry_reg.tag[13:7];
    assign rsp.out_roll   = out_entry_reg.tag[6:0];
    assign rsp.out_score  = out_entry_reg.key;
    assign rsp.last       = out_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CntW'(CAPACITY))
        else $error("fill count above capacity");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (list_cnt_reg != '0) && (list_cnt_reg <= fill_reg))
        else $error("list walk with bad remaining count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == CMD_INSERT) && !full)
        |=> (fill_reg == $past(fill_reg) + CntW'(1)))
        else $error("insert did not grow the queue");

    a_list_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_free && (list_cnt_reg == CntW'(1)))
        |=> (rsp.valid && rsp.last && !busy_reg))
        else $error("list end not marked");

endmodule

[hw/rtl/spq_cell.sv]
// spq_cell: one slot of the sorted chain, holds a score and its tag
// depends on spq_pkg; instantiated in a row by sorted_priority_queue_top
module spq_cell
    import spq_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    prev_entry,
    input  logic      prev_goes,
    input  entry_t    next_entry,
    input  entry_t    head_entry,
    output entry_t    entry,
    output logic      goes
);

    entry_t entry_reg;
    entry_t entry_next;

    // slot moves down when empty or its score is not above the new one
    assign goes = !ctl.occ || (entry_reg.key <= new_entry.key);

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            OP_INSERT:
            begin
                if (goes)
                begin
                    entry_next = prev_goes ? prev_entry : new_entry;
                end
            end
            OP_SHIFT:
            begin
                entry_next = ctl.is_tail ? head_entry : next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
